@@ hdl/rcd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcd_pkg: shared definitions for the RESP command deframer
// Parse phase codes, configuration register indexes, error codes, character
// codes and widths used by the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rcd_pkg;

	localparam int NUM_W   = 17;
	localparam int POS_W   = 8;
	localparam int LEN_W   = 17;
	localparam int PHASE_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam int ERR_W   = 3;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_COUNT   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_DOLLAR  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DATA    = 3'd4;
	localparam logic [PHASE_W-1:0] PH_TRAILER = 3'd5;
	localparam logic [PHASE_W-1:0] PH_INLINE  = 3'd6;
	localparam logic [PHASE_W-1:0] PH_ERROR   = 3'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BULK_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_LIMIT = 2'd2;

	localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
	localparam logic [ERR_W-1:0] ERR_BAD_COUNT    = 3'd1;
	localparam logic [ERR_W-1:0] ERR_NO_DOLLAR    = 3'd2;
	localparam logic [ERR_W-1:0] ERR_BAD_LENGTH   = 3'd3;
	localparam logic [ERR_W-1:0] ERR_TOO_LARGE    = 3'd4;
	localparam logic [ERR_W-1:0] ERR_TOO_MANY     = 3'd5;

	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [POS_W-1:0] ELEMENT_LIMIT_RESET = 8'd255;
	localparam logic [LEN_W-1:0] LENGTH_MAX          = 17'd65536;

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
			(c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
	endfunction

endpackage

`default_nettype wire

@@ hdl/resp_command_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// resp_command_deframer_unit: RESP request deframer
// Splits a client byte stream, one byte per cycle unless stalled, into command
// elements: RESP arrays of bulk strings or inline whitespace separated lines.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Contents
//  in        sink       in_valid / in_ready    action, data_byte
//  out       source     out_valid / out_ready  out_byte .. error_code
//  cfg       sink       cfg_write              cfg_index, cfg_data
//
//  Each byte transaction is parsed combinationally and its result, if any, is
//  held in an output register, so a new transaction is taken every cycle the
//  output is not stalled. That register is the single stage before the result.
//  Input is taken whenever the output register is empty or being drained.
//  Reset restores the register defaults and leaves the parser idle.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_command_deframer_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [rcd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rcd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              action,
	input  wire logic [7:0]                        data_byte,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             out_byte,
	output logic                                   has_byte,
	output logic [rcd_pkg::POS_W-1:0]              element_index,
	output logic                                   element_end,
	output logic                                   command_end,
	output logic                                   inline_form,
	output logic [rcd_pkg::ERR_W-1:0]              error_code
);

	logic [rcd_pkg::POS_W-1:0]   elem_lim_q;
	logic [rcd_pkg::LEN_W-1:0]   bulk_lim_q;
	logic [rcd_pkg::LEN_W-1:0]   cmd_lim_q;

	logic [rcd_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [rcd_pkg::NUM_W-1:0]   num_q, num_d;
	logic                        neg_q, neg_d;
	logic                        sign_q, sign_d;
	logic                        digit_q, digit_d;
	logic                        done_q, done_d;
	logic                        cr_q, cr_d;
	logic [rcd_pkg::POS_W-1:0]   left_q, left_d;
	logic [rcd_pkg::POS_W-1:0]   pos_q, pos_d;
	logic [rcd_pkg::LEN_W-1:0]   bulk_q, bulk_d;
	logic [1:0]                  trl_q, trl_d;
	logic [rcd_pkg::LEN_W-1:0]   cnt_q, cnt_d;
	logic                        word_q, word_d;

	logic                        accept;
	logic                        emit;
	logic [7:0]                  e_byte;
	logic                        e_has;
	logic                        e_eend;
	logic                        e_cend;
	logic                        e_inl;
	logic [rcd_pkg::ERR_W-1:0]   e_err;
	logic                        end_cmd;
	logic                        start_num;
	logic                        do_inline;
	logic                        do_close;
	logic                        do_fail;
	logic [20:0]                 num_ext;
	logic                        is_digit;

	logic [rcd_pkg::LEN_W-1:0]   bulk_lim_eff;
	logic [rcd_pkg::LEN_W-1:0]   cmd_lim_eff;

	assign accept = in_valid && in_ready;
	assign in_ready = !out_valid || out_ready;

	assign bulk_lim_eff = (bulk_lim_q > rcd_pkg::LENGTH_MAX) ? rcd_pkg::LENGTH_MAX : bulk_lim_q;
	assign cmd_lim_eff = (cmd_lim_q > rcd_pkg::LENGTH_MAX) ? rcd_pkg::LENGTH_MAX : cmd_lim_q;

	assign is_digit = (data_byte >= rcd_pkg::CH_ZERO) && (data_byte <= rcd_pkg::CH_NINE);
	assign num_ext = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} +
		{13'd0, data_byte - rcd_pkg::CH_ZERO};

	always_comb begin
		phase_d = phase_q;
		num_d = num_q;
		neg_d = neg_q;
		sign_d = sign_q;
		digit_d = digit_q;
		done_d = done_q;
		cr_d = cr_q;
		left_d = left_q;
		pos_d = pos_q;
		bulk_d = bulk_q;
		trl_d = trl_q;
		cnt_d = cnt_q;
		word_d = word_q;
		emit = 1'b0;
		e_byte = 8'd0;
		e_has = 1'b0;
		e_eend = 1'b0;
		e_cend = 1'b0;
		e_inl = 1'b0;
		e_err = rcd_pkg::ERR_NONE;
		end_cmd = 1'b0;
		start_num = 1'b0;
		do_inline = 1'b0;
		do_close = 1'b0;
		do_fail = 1'b0;

		if (accept) begin
			if (action) begin
				end_cmd = 1'b1;
			end else if (phase_q != rcd_pkg::PH_ERROR) begin
				if (cnt_q >= cmd_lim_eff) begin
					do_fail = 1'b1;
					e_err = rcd_pkg::ERR_TOO_LARGE;
					e_inl = (phase_q == rcd_pkg::PH_INLINE);
				end else begin
					cnt_d = cnt_q + 1'b1;
					case (phase_q)
						rcd_pkg::PH_IDLE: begin
							if (data_byte == rcd_pkg::CH_STAR) begin
								start_num = 1'b1;
								phase_d = rcd_pkg::PH_COUNT;
							end else begin
								phase_d = rcd_pkg::PH_INLINE;
								do_inline = 1'b1;
							end
						end
						rcd_pkg::PH_INLINE: begin
							do_inline = 1'b1;
						end
						rcd_pkg::PH_COUNT, rcd_pkg::PH_LENGTH: begin
							if (!(cr_q && data_byte == rcd_pkg::CH_LF)) begin
								cr_d = (data_byte == rcd_pkg::CH_CR);
								if (!done_q) begin
									if (!digit_q && !sign_q && rcd_pkg::is_space(data_byte)) begin
										done_d = 1'b0;
									end else if (!digit_q && !sign_q &&
										(data_byte == rcd_pkg::CH_PLUS ||
										data_byte == rcd_pkg::CH_MINUS)) begin
										sign_d = 1'b1;
										neg_d = (data_byte == rcd_pkg::CH_MINUS);
									end else if (is_digit) begin
										digit_d = 1'b1;
										num_d = (num_ext[20:17] != 4'd0) ? {rcd_pkg::NUM_W{1'b1}} :
											num_ext[rcd_pkg::NUM_W-1:0];
									end else begin
										done_d = 1'b1;
									end
								end
							end else if (phase_q == rcd_pkg::PH_COUNT) begin
								if (!digit_q) begin
									do_fail = 1'b1;
									e_err = rcd_pkg::ERR_BAD_COUNT;
								end else if (neg_q || num_q == '0) begin
									end_cmd = 1'b1;
								end else if (num_q > {9'd0, elem_lim_q}) begin
									do_fail = 1'b1;
									e_err = rcd_pkg::ERR_TOO_MANY;
								end else begin
									left_d = num_q[rcd_pkg::POS_W-1:0];
									pos_d = '0;
									phase_d = rcd_pkg::PH_DOLLAR;
								end
							end else begin
								if (!digit_q) begin
									do_fail = 1'b1;
									e_err = rcd_pkg::ERR_BAD_LENGTH;
								end else if (neg_q && num_q != '0) begin
									do_close = 1'b1;
								end else if (num_q > bulk_lim_eff) begin
									do_fail = 1'b1;
									e_err = rcd_pkg::ERR_BAD_LENGTH;
								end else if (num_q == '0) begin
									trl_d = 2'd2;
									phase_d = rcd_pkg::PH_TRAILER;
								end else begin
									bulk_d = num_q;
									phase_d = rcd_pkg::PH_DATA;
								end
							end
						end
						rcd_pkg::PH_DOLLAR: begin
							if (data_byte != rcd_pkg::CH_DOLLAR) begin
								do_fail = 1'b1;
								e_err = rcd_pkg::ERR_NO_DOLLAR;
							end else begin
								start_num = 1'b1;
								phase_d = rcd_pkg::PH_LENGTH;
							end
						end
						rcd_pkg::PH_DATA: begin
							emit = 1'b1;
							e_byte = data_byte;
							e_has = 1'b1;
							if (bulk_q != '0) begin
								bulk_d = bulk_q - 1'b1;
							end
							if (bulk_q <= 17'd1) begin
								trl_d = 2'd2;
								phase_d = rcd_pkg::PH_TRAILER;
							end
						end
						rcd_pkg::PH_TRAILER: begin
							if (trl_q != 2'd0) begin
								trl_d = trl_q - 1'b1;
							end
							if (trl_q <= 2'd1) begin
								do_close = 1'b1;
							end
						end
						default: begin
							phase_d = phase_q;
						end
					endcase

					if (do_inline) begin
						if (data_byte == rcd_pkg::CH_LF) begin
							if (word_q) begin
								emit = 1'b1;
								e_eend = 1'b1;
								e_cend = 1'b1;
								e_inl = 1'b1;
							end else if (pos_q != '0) begin
								emit = 1'b1;
								e_cend = 1'b1;
								e_inl = 1'b1;
							end
							end_cmd = 1'b1;
						end else if (rcd_pkg::is_space(data_byte)) begin
							if (word_q) begin
								emit = 1'b1;
								e_eend = 1'b1;
								e_inl = 1'b1;
								pos_d = pos_q + 1'b1;
								word_d = 1'b0;
							end
						end else if (!word_q && pos_q >= elem_lim_q) begin
							do_fail = 1'b1;
							e_err = rcd_pkg::ERR_TOO_MANY;
							e_inl = 1'b1;
						end else begin
							word_d = 1'b1;
							emit = 1'b1;
							e_byte = data_byte;
							e_has = 1'b1;
							e_inl = 1'b1;
						end
					end

					if (do_close) begin
						emit = 1'b1;
						e_eend = 1'b1;
						e_cend = (left_q <= 8'd1);
						if (left_q <= 8'd1) begin
							end_cmd = 1'b1;
						end else begin
							left_d = left_q - 1'b1;
							pos_d = pos_q + 1'b1;
							phase_d = rcd_pkg::PH_DOLLAR;
						end
					end
				end
			end
		end

		if (end_cmd) begin
			phase_d = rcd_pkg::PH_IDLE;
			cnt_d = '0;
			left_d = '0;
			pos_d = '0;
			bulk_d = '0;
			trl_d = 2'd0;
			word_d = 1'b0;
			start_num = 1'b1;
		end
		if (start_num) begin
			num_d = '0;
			neg_d = 1'b0;
			sign_d = 1'b0;
			digit_d = 1'b0;
			done_d = 1'b0;
			cr_d = 1'b0;
		end
		if (do_fail) begin
			phase_d = rcd_pkg::PH_ERROR;
			emit = 1'b1;
			e_byte = 8'd0;
			e_has = 1'b0;
			e_eend = 1'b0;
			e_cend = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_lim_q <= rcd_pkg::ELEMENT_LIMIT_RESET;
			bulk_lim_q <= rcd_pkg::LENGTH_MAX;
			cmd_lim_q <= rcd_pkg::LENGTH_MAX;
		end else if (cfg_write) begin
			case (cfg_index)
				rcd_pkg::CFG_ELEMENT_LIMIT: elem_lim_q <= cfg_data[rcd_pkg::POS_W-1:0];
				rcd_pkg::CFG_BULK_LIMIT: bulk_lim_q <= cfg_data;
				rcd_pkg::CFG_COMMAND_LIMIT: cmd_lim_q <= cfg_data;
				default: elem_lim_q <= elem_lim_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rcd_pkg::PH_IDLE;
			num_q <= '0;
			neg_q <= 1'b0;
			sign_q <= 1'b0;
			digit_q <= 1'b0;
			done_q <= 1'b0;
			cr_q <= 1'b0;
			left_q <= '0;
			pos_q <= '0;
			bulk_q <= '0;
			trl_q <= 2'd0;
			cnt_q <= '0;
			word_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			num_q <= num_d;
			neg_q <= neg_d;
			sign_q <= sign_d;
			digit_q <= digit_d;
			done_q <= done_d;
			cr_q <= cr_d;
			left_q <= left_d;
			pos_q <= pos_d;
			bulk_q <= bulk_d;
			trl_q <= trl_d;
			cnt_q <= cnt_d;
			word_q <= word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= emit;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_byte <= e_byte;
			has_byte <= e_has;
			element_index <= pos_q;
			element_end <= e_eend;
			command_end <= e_cend;
			inline_form <= e_inl;
			error_code <= e_err;
		end
	end

endmodule

`default_nettype wire
